// ===== src/gcc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gcc_pkg;

  // Grid limits; a configured size above these is clamped.
  localparam int unsigned MAX_ROWS = 64;
  localparam int unsigned MAX_COLS = 64;

  localparam int unsigned COORD_W = 7;
  localparam int unsigned CNT_W   = 7;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam int unsigned ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  // The final check walks every store entry once.
  localparam int unsigned WALK_LEN = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int unsigned WALK_AW  = (WALK_LEN > 1) ? $clog2(WALK_LEN) : 1;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned CFG_IDX_W   = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS = 1'b0,
    REG_GRID_COLS = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SETTLE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  // Write requests from the update stage to the three stores.
  typedef struct packed {
    logic                row_we;
    logic [ROW_AW-1:0]   row_addr;
    logic [CNT_W-1:0]    row_data;
    logic                col_we;
    logic [COL_AW-1:0]   col_addr;
    logic [CNT_W-1:0]    col_data;
    logic                map_we;
    logic [ROW_AW-1:0]   map_addr;
    logic [MAX_COLS-1:0] map_data;
  } store_wr_t;

  // Walk sequencer status towards the control FSM.
  typedef struct packed {
    logic [WALK_AW-1:0] idx;
    logic               last;
    logic               bad;
  } walk_stat_t;

endpackage

`default_nettype wire

// ===== src/gcc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Single-port-write, single-port-read RAM with registered read data.
// Entries not written since the last clear read as zero.
module gcc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             clr_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [WIDTH-1:0] rdata_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (clr_i) begin
        vld_q <= '0;
      end else if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire

// ===== src/gcc_update.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Read-modify-write stage: the stores are read when a cell is taken,
// the bumped counts and map row are written in the cycle after.
module gcc_update (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          clr_i,
  input  wire logic                          take_i,
  input  wire logic [gcc_pkg::COORD_W-1:0]   cell_row_i,
  input  wire logic [gcc_pkg::COORD_W-1:0]   cell_col_i,
  input  wire logic                          cell_kept_i,
  input  wire logic [gcc_pkg::CNT_W-1:0]     rows_use_i,
  input  wire logic [gcc_pkg::CNT_W-1:0]     cols_use_i,
  input  wire logic [gcc_pkg::CNT_W-1:0]     row_rd_i,
  input  wire logic [gcc_pkg::CNT_W-1:0]     col_rd_i,
  input  wire logic [gcc_pkg::MAX_COLS-1:0]  map_rd_i,
  output gcc_pkg::store_wr_t                 wr_o,
  output logic                               stray_o
);

  logic                          v_q;
  logic                          row_ok_q;
  logic                          col_ok_q;
  logic [gcc_pkg::ROW_AW-1:0]    row_idx_q;
  logic [gcc_pkg::COL_AW-1:0]    col_idx_q;

  // Most recent write to each store, forwarded to a read that raced it.
  logic                          fw_row_vld_q;
  logic [gcc_pkg::ROW_AW-1:0]    fw_row_addr_q;
  logic [gcc_pkg::CNT_W-1:0]     fw_row_data_q;
  logic                          fw_col_vld_q;
  logic [gcc_pkg::COL_AW-1:0]    fw_col_addr_q;
  logic [gcc_pkg::CNT_W-1:0]     fw_col_data_q;
  logic                          fw_map_vld_q;
  logic [gcc_pkg::ROW_AW-1:0]    fw_map_addr_q;
  logic [gcc_pkg::MAX_COLS-1:0]  fw_map_data_q;

  logic                          stray_q;
  logic                          stray_d;

  logic [gcc_pkg::CNT_W-1:0]     row_cur;
  logic [gcc_pkg::CNT_W-1:0]     col_cur;
  logic [gcc_pkg::MAX_COLS-1:0]  map_cur;

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      row_ok_q  <= cell_row_i < rows_use_i;
      col_ok_q  <= cell_col_i < cols_use_i;
      row_idx_q <= cell_row_i[gcc_pkg::ROW_AW-1:0];
      col_idx_q <= cell_col_i[gcc_pkg::COL_AW-1:0];
    end
  end

  always_comb begin
    row_cur = (fw_row_vld_q && fw_row_addr_q == row_idx_q) ? fw_row_data_q : row_rd_i;
    col_cur = (fw_col_vld_q && fw_col_addr_q == col_idx_q) ? fw_col_data_q : col_rd_i;
    map_cur = (fw_map_vld_q && fw_map_addr_q == row_idx_q) ? fw_map_data_q : map_rd_i;

    wr_o.row_we   = v_q && row_ok_q;
    wr_o.row_addr = row_idx_q;
    wr_o.row_data = (row_cur == gcc_pkg::CNT_MAX) ? row_cur : row_cur + 1'b1;
    wr_o.col_we   = v_q && col_ok_q;
    wr_o.col_addr = col_idx_q;
    wr_o.col_data = (col_cur == gcc_pkg::CNT_MAX) ? col_cur : col_cur + 1'b1;
    wr_o.map_we   = v_q && row_ok_q && col_ok_q;
    wr_o.map_addr = row_idx_q;
    wr_o.map_data = map_cur | (gcc_pkg::MAX_COLS'(1) << col_idx_q);

    stray_d = stray_q || (v_q && !(row_ok_q && col_ok_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q          <= 1'b0;
      fw_row_vld_q <= 1'b0;
      fw_col_vld_q <= 1'b0;
      fw_map_vld_q <= 1'b0;
      stray_q      <= 1'b0;
    end else if (clr_i) begin
      v_q          <= 1'b0;
      fw_row_vld_q <= 1'b0;
      fw_col_vld_q <= 1'b0;
      fw_map_vld_q <= 1'b0;
      stray_q      <= 1'b0;
    end else begin
      v_q     <= take_i && !cell_kept_i;
      stray_q <= stray_d;
      if (wr_o.row_we) begin
        fw_row_vld_q <= 1'b1;
      end
      if (wr_o.col_we) begin
        fw_col_vld_q <= 1'b1;
      end
      if (wr_o.map_we) begin
        fw_map_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_o.row_we) begin
      fw_row_addr_q <= wr_o.row_addr;
      fw_row_data_q <= wr_o.row_data;
    end
    if (wr_o.col_we) begin
      fw_col_addr_q <= wr_o.col_addr;
      fw_col_data_q <= wr_o.col_data;
    end
    if (wr_o.map_we) begin
      fw_map_addr_q <= wr_o.map_addr;
      fw_map_data_q <= wr_o.map_data;
    end
  end

  assign stray_o = stray_q;

endmodule

`default_nettype wire

// ===== src/gcc_walk.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Check sequencer: reads one store entry a cycle and folds it in.
// u_q collects map bits of rows that are not full; col_full_q marks full columns.
module gcc_walk (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic                          run_i,
  input  wire logic [gcc_pkg::CNT_W-1:0]     rows_use_i,
  input  wire logic [gcc_pkg::CNT_W-1:0]     cols_use_i,
  input  wire logic [gcc_pkg::CNT_W-1:0]     row_cnt_i,
  input  wire logic [gcc_pkg::CNT_W-1:0]     col_cnt_i,
  input  wire logic [gcc_pkg::MAX_COLS-1:0]  map_row_i,
  output gcc_pkg::walk_stat_t                stat_o
);

  logic [gcc_pkg::WALK_AW-1:0]   idx_q;
  logic                          pend_q;
  logic [gcc_pkg::WALK_AW-1:0]   ridx_q;
  logic [gcc_pkg::MAX_COLS-1:0]  u_q;
  logic [gcc_pkg::MAX_COLS-1:0]  u_d;
  logic [gcc_pkg::MAX_COLS-1:0]  col_full_q;
  logic [gcc_pkg::MAX_COLS-1:0]  col_full_d;
  logic [gcc_pkg::MAX_COLS-1:0]  col_mask;
  logic                          row_in;
  logic                          col_in;
  logic                          row_full;
  logic                          col_full;

  always_comb begin
    row_in   = (gcc_pkg::CNT_W + 1)'(ridx_q) < {1'b0, rows_use_i};
    col_in   = (gcc_pkg::CNT_W + 1)'(ridx_q) < {1'b0, cols_use_i};
    row_full = row_cnt_i == cols_use_i;
    col_full = col_cnt_i == rows_use_i;

    u_d = u_q;
    if (pend_q && row_in && !row_full) begin
      u_d = u_q | map_row_i;
    end

    col_full_d = col_full_q;
    for (int k = 0; k < gcc_pkg::MAX_COLS; k++) begin
      col_mask[k] = (gcc_pkg::CNT_W + 1)'(k) < {1'b0, cols_use_i};
      if (pend_q && col_in && ridx_q == gcc_pkg::WALK_AW'(k)) begin
        col_full_d[k] = col_full;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      pend_q <= 1'b0;
    end else if (start_i) begin
      idx_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      pend_q <= run_i;
      if (run_i) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      u_q        <= '0;
      col_full_q <= '0;
    end else begin
      u_q        <= u_d;
      col_full_q <= col_full_d;
    end
    if (run_i) begin
      ridx_q <= idx_q;
    end
  end

  assign stat_o.idx  = idx_q;
  assign stat_o.last = idx_q == gcc_pkg::WALK_AW'(gcc_pkg::WALK_LEN - 1);
  assign stat_o.bad  = |(u_q & ~col_full_q & col_mask);

endmodule

`default_nettype wire

// ===== src/grid_collapse_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Grid collapse check. Stream in the cells of a grid, one request per cell:
// row, column and kept flag in tdata, tlast on the final cell. Removed cells
// are tallied per row and per column (saturating at 127) and marked in a
// removal map; all three live in RAMs that are read when a cell is taken and
// written back in the following cycle, with forwarding so that cells arrive
// at one per cycle while loading, with no restriction on repeats. On the final
// cell the block stops taking cells, walks the RAMs once (one entry per cycle,
// MAX_ROWS or MAX_COLS entries, whichever is larger) and then offers one
// result: tdata[0] is 1 when every removed cell lies in a full row or a full
// column, tdata[1] flags an empty grid (zero rows or zero columns, answer then
// 0). A removed cell outside the configured grid also forces the answer to 0.
// While the settle, walk, drain and finish states run, no cell is taken.
// State clears when the result is loaded into the output register, without a
// clearing pass, so a new grid may start while the result waits to be taken.
// Write grid_rows (index 0) and grid_cols (index 1) only between grids; a
// size above the build limit is clamped to it.
module grid_collapse_check (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Cell requests
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [6:0] cell_row, [13:7] cell_col, [14] cell_kept, [15] zero
  input  wire logic [gcc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  wire logic                                s_axis_tlast,
  // Result requests
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [0] collapsible, [1] empty_grid, [7:2] zero
  output logic      [gcc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // Configuration writes
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [gcc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [gcc_pkg::CNT_W-1:0]           cfg_data_i
);

  gcc_pkg::state_e state_q;
  gcc_pkg::state_e state_d;

  logic [gcc_pkg::CNT_W-1:0]     grid_rows_q;
  logic [gcc_pkg::CNT_W-1:0]     grid_cols_q;
  logic [gcc_pkg::CNT_W-1:0]     rows_use;
  logic [gcc_pkg::CNT_W-1:0]     cols_use;

  logic [gcc_pkg::COORD_W-1:0]   cell_row;
  logic [gcc_pkg::COORD_W-1:0]   cell_col;
  logic                          cell_kept;

  logic                          s_fire;
  logic                          cfg_fire;
  logic                          walk_start;
  logic                          walk_run;
  logic                          clr;
  logic                          out_load;
  logic                          empty;

  logic                          out_valid_q;
  logic                          out_coll_q;
  logic                          out_empty_q;

  gcc_pkg::store_wr_t            wr;
  gcc_pkg::walk_stat_t           walk;
  logic                          stray;

  logic                          rd_en;
  logic [gcc_pkg::ROW_AW-1:0]    row_raddr;
  logic [gcc_pkg::COL_AW-1:0]    col_raddr;
  logic [gcc_pkg::CNT_W-1:0]     row_rd;
  logic [gcc_pkg::CNT_W-1:0]     col_rd;
  logic [gcc_pkg::MAX_COLS-1:0]  map_rd;

  // Unpack the cell request.
  assign cell_row  = s_axis_tdata[gcc_pkg::COORD_W-1:0];
  assign cell_col  = s_axis_tdata[2*gcc_pkg::COORD_W-1:gcc_pkg::COORD_W];
  assign cell_kept = s_axis_tdata[2*gcc_pkg::COORD_W];

  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;

  // Configuration registers; the port never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= '0;
      grid_cols_q <= '0;
    end else if (cfg_fire) begin
      unique case (gcc_pkg::cfg_reg_e'(cfg_index_i))
        gcc_pkg::REG_GRID_ROWS: grid_rows_q <= cfg_data_i;
        gcc_pkg::REG_GRID_COLS: grid_cols_q <= cfg_data_i;
      endcase
    end
  end

  // Clamp the grid to the build limits.
  assign rows_use = ({1'b0, grid_rows_q} > (gcc_pkg::CNT_W + 1)'(gcc_pkg::MAX_ROWS))
                  ? gcc_pkg::CNT_W'(gcc_pkg::MAX_ROWS) : grid_rows_q;
  assign cols_use = ({1'b0, grid_cols_q} > (gcc_pkg::CNT_W + 1)'(gcc_pkg::MAX_COLS))
                  ? gcc_pkg::CNT_W'(gcc_pkg::MAX_COLS) : grid_cols_q;
  assign empty    = (rows_use == '0) || (cols_use == '0);

  // Read ports: the walk index while walking, the cell coordinates otherwise.
  assign rd_en     = s_fire || walk_run;
  assign row_raddr = walk_run ? walk.idx[gcc_pkg::ROW_AW-1:0]
                              : cell_row[gcc_pkg::ROW_AW-1:0];
  assign col_raddr = walk_run ? walk.idx[gcc_pkg::COL_AW-1:0]
                              : cell_col[gcc_pkg::COL_AW-1:0];

  gcc_ram #(
    .WIDTH (gcc_pkg::CNT_W),
    .DEPTH (gcc_pkg::MAX_ROWS)
  ) u_row_cnt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (clr),
    .we_i    (wr.row_we),
    .waddr_i (wr.row_addr),
    .wdata_i (wr.row_data),
    .re_i    (rd_en),
    .raddr_i (row_raddr),
    .rdata_o (row_rd)
  );

  gcc_ram #(
    .WIDTH (gcc_pkg::CNT_W),
    .DEPTH (gcc_pkg::MAX_COLS)
  ) u_col_cnt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (clr),
    .we_i    (wr.col_we),
    .waddr_i (wr.col_addr),
    .wdata_i (wr.col_data),
    .re_i    (rd_en),
    .raddr_i (col_raddr),
    .rdata_o (col_rd)
  );

  gcc_ram #(
    .WIDTH (gcc_pkg::MAX_COLS),
    .DEPTH (gcc_pkg::MAX_ROWS)
  ) u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (clr),
    .we_i    (wr.map_we),
    .waddr_i (wr.map_addr),
    .wdata_i (wr.map_data),
    .re_i    (rd_en),
    .raddr_i (row_raddr),
    .rdata_o (map_rd)
  );

  gcc_update u_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (clr),
    .take_i      (s_fire),
    .cell_row_i  (cell_row),
    .cell_col_i  (cell_col),
    .cell_kept_i (cell_kept),
    .rows_use_i  (rows_use),
    .cols_use_i  (cols_use),
    .row_rd_i    (row_rd),
    .col_rd_i    (col_rd),
    .map_rd_i    (map_rd),
    .wr_o        (wr),
    .stray_o     (stray)
  );

  gcc_walk u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (walk_start),
    .run_i      (walk_run),
    .rows_use_i (rows_use),
    .cols_use_i (cols_use),
    .row_cnt_i  (row_rd),
    .col_cnt_i  (col_rd),
    .map_row_i  (map_rd),
    .stat_o     (walk)
  );

  // Control: load cells, let the last write-back land, walk, drain, answer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gcc_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    walk_start    = 1'b0;
    walk_run      = 1'b0;
    out_load      = 1'b0;
    clr           = 1'b0;
    unique case (state_q)
      gcc_pkg::ST_LOAD: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && s_axis_tlast) begin
          state_d = gcc_pkg::ST_SETTLE;
        end
      end
      gcc_pkg::ST_SETTLE: begin
        // The final cell's write-back lands at the end of this cycle.
        walk_start = 1'b1;
        state_d    = gcc_pkg::ST_WALK;
      end
      gcc_pkg::ST_WALK: begin
        walk_run = 1'b1;
        if (walk.last) begin
          state_d = gcc_pkg::ST_DRAIN;
        end
      end
      gcc_pkg::ST_DRAIN: begin
        state_d = gcc_pkg::ST_FINISH;
      end
      gcc_pkg::ST_FINISH: begin
        // Hold until the output register is free, then answer and clear.
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          clr      = 1'b1;
          state_d  = gcc_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = gcc_pkg::ST_LOAD;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_coll_q  <= !empty && !stray && !walk.bad;
      out_empty_q <= empty;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(gcc_pkg::OUT_TDATA_W - 2){1'b0}}, out_empty_q, out_coll_q};

  // No store write may overlap the walk.
  a_no_write_in_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gcc_pkg::ST_WALK || state_q == gcc_pkg::ST_DRAIN)
      |-> !(wr.row_we || wr.col_we || wr.map_we))
    else $error("store written during the check walk");

  // Clearing happens only when a result can be loaded without loss.
  a_clear_safe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr |-> (!out_valid_q || m_axis_tready))
    else $error("state cleared while a result is still held");

  // No cell is taken in the cycle after the final cell.
  a_stall_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_axis_tlast) |=> !s_axis_tready)
    else $error("cell taken while the check is pending");

endmodule

`default_nettype wire

// ===== bench/tb_grid_collapse_check.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the grid collapse check.
// Cells go in as stream requests. Each accepted cell feeds a local tally of
// removals per row and per column, kept in step with the block. The grid
// verdict is worked out on the final cell and compared against the result
// request that comes back.
module tb_grid_collapse_check;

  // Cycles without any accepted request before the run is declared hung.
  // The limit is far past the final-cell walk or any other legal pause.
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned CELL_BUDGET = 1950;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [gcc_pkg::COORD_W-1:0] row;
    logic [gcc_pkg::COORD_W-1:0] col;
    logic                        kept;
    logic                        last;
  } cell_t;

  typedef struct packed {
    logic collapsible;
    logic empty_grid;
  } verdict_t;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  // [6:0] cell_row, [13:7] cell_col, [14] cell_kept, [15] zero
  logic [gcc_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                            s_axis_tlast  = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // [0] collapsible, [1] empty_grid, [7:2] zero
  logic [gcc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            cfg_valid_i   = 1'b0;
  logic                            cfg_ready_o;
  logic [gcc_pkg::CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [gcc_pkg::CNT_W-1:0]       cfg_data_i    = '0;

  // Local copy of the block's grid state and its two size registers.
  logic [gcc_pkg::MAX_COLS-1:0] cut_map   [gcc_pkg::MAX_ROWS];
  logic [gcc_pkg::CNT_W-1:0]    row_tally [gcc_pkg::MAX_ROWS];
  logic [gcc_pkg::CNT_W-1:0]    col_tally [gcc_pkg::MAX_COLS];
  logic                         stray_cut;
  logic [gcc_pkg::CNT_W-1:0]    rows_set = '0;
  logic [gcc_pkg::CNT_W-1:0]    cols_set = '0;

  cell_t    cell_q[$];        // cells waiting to be offered
  cell_t    batch[$];         // one grid under construction
  verdict_t verdicts_due[$];  // verdicts owed by the block, oldest first

  int unsigned send_idle_pct    = 0;
  int unsigned recv_idle_pct    = 0;
  int unsigned mismatches       = 0;
  int unsigned cells_queued     = 0;
  int unsigned grids_queued     = 0;
  int unsigned settings_written = 0;
  int unsigned verdicts_checked = 0;
  int unsigned quiet_cycles     = 0;
  logic        cell_acc         = 1'b0;

  // Sizes visited every fourth setting: extremes, empty grids and values
  // above the build limit, which the block clamps.
  logic [gcc_pkg::CNT_W-1:0] fixed_rows [9] =
    '{7'd64, 7'd1, 7'd64, 7'd1, 7'd0, 7'd7, 7'd127, 7'd100, 7'd0};
  logic [gcc_pkg::CNT_W-1:0] fixed_cols [9] =
    '{7'd64, 7'd1, 7'd1, 7'd64, 7'd5, 7'd0, 7'd127, 7'd3, 7'd0};

  grid_collapse_check uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned span(logic [gcc_pkg::CNT_W-1:0] v, int unsigned lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic void note_miss(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endfunction

  function automatic void wipe_grid();
    int unsigned i;
    for (i = 0; i < gcc_pkg::MAX_ROWS; i++) begin
      cut_map[i]   = '0;
      row_tally[i] = '0;
    end
    for (i = 0; i < gcc_pkg::MAX_COLS; i++) col_tally[i] = '0;
    stray_cut = 1'b0;
  endfunction

  // Fold one accepted cell into the tallies; on the final cell, decide the
  // grid, queue the verdict and clear the tallies.
  function automatic void absorb_cell(cell_t c);
    int unsigned nr, nc, r, k;
    logic        row_in, col_in, covered;
    verdict_t    v;
    nr = span(rows_set, gcc_pkg::MAX_ROWS);
    nc = span(cols_set, gcc_pkg::MAX_COLS);
    if (!c.kept) begin
      row_in = c.row < nr;
      col_in = c.col < nc;
      // An in-range coordinate still counts even when its partner is stray.
      if (row_in && row_tally[c.row[gcc_pkg::ROW_AW-1:0]] != gcc_pkg::CNT_MAX)
        row_tally[c.row[gcc_pkg::ROW_AW-1:0]] = row_tally[c.row[gcc_pkg::ROW_AW-1:0]] + 1'b1;
      if (col_in && col_tally[c.col[gcc_pkg::COL_AW-1:0]] != gcc_pkg::CNT_MAX)
        col_tally[c.col[gcc_pkg::COL_AW-1:0]] = col_tally[c.col[gcc_pkg::COL_AW-1:0]] + 1'b1;
      if (row_in && col_in)
        cut_map[c.row[gcc_pkg::ROW_AW-1:0]][c.col[gcc_pkg::COL_AW-1:0]] = 1'b1;
      else stray_cut = 1'b1;
    end
    if (c.last) begin
      v.empty_grid = (nr == 0) || (nc == 0);
      covered = !stray_cut;
      for (r = 0; r < nr; r++)
        for (k = 0; k < nc; k++)
          if (cut_map[r][k] && row_tally[r] != nc && col_tally[k] != nr) covered = 1'b0;
      v.collapsible = !v.empty_grid && covered;
      verdicts_due.insert(verdicts_due.size(), v);
      wipe_grid();
    end
  endfunction

  function automatic void add_cell(int unsigned r, int unsigned c, logic kept);
    cell_t t;
    t.row  = r[gcc_pkg::COORD_W-1:0];
    t.col  = c[gcc_pkg::COORD_W-1:0];
    t.kept = kept;
    t.last = 1'b0;
    batch.insert(batch.size(), t);
  endfunction

  // Close the grid under construction: give an empty one a random kept cell,
  // optionally shuffle it, mark its final cell and hand it to the driver.
  function automatic void ship(logic mix);
    cell_t t;
    int    j, k;
    if (batch.size() == 0) add_cell($urandom_range(0, 127), $urandom_range(0, 127), 1'b1);
    if (mix) begin
      for (j = batch.size() - 1; j > 0; j--) begin
        k        = $urandom_range(0, j);
        t        = batch[j];
        batch[j] = batch[k];
        batch[k] = t;
      end
    end
    t      = batch[batch.size() - 1];
    t.last = 1'b1;
    batch[batch.size() - 1] = t;
    for (j = 0; j < batch.size(); j++) cell_q.insert(cell_q.size(), batch[j]);
    cells_queued += batch.size();
    grids_queued++;
    batch.delete();
  endfunction

  // Build one random grid of nr x nc cells. Most grids remove whole rows and
  // whole columns; the rest are spoilt in one way or another.
  function automatic void queue_grid(int unsigned nr, int unsigned nc);
    logic [gcc_pkg::MAX_COLS-1:0] cut [gcc_pkg::MAX_ROWS];
    int unsigned                  r, k, n, flavour, reps;
    logic                         fill;
    cell_t                        t;
    flavour = $urandom_range(0, 99);
    for (r = 0; r < gcc_pkg::MAX_ROWS; r++) cut[r] = '0;
    if (nr == 0 || nc == 0) begin
      // Empty grid: whatever arrives, the answer is the empty one.
      repeat ($urandom_range(1, 4))
        add_cell($urandom_range(0, 127), $urandom_range(0, 127), 1'($urandom_range(0, 1)));
    end else if (flavour >= 98) begin
      // Hammer one cell near or past the tally ceiling. A tally that wraps
      // instead of holding at its maximum can land on nc and fake a full row.
      r    = $urandom_range(0, nr - 1);
      k    = $urandom_range(0, nc - 1);
      reps = $urandom_range(0, 1) ? 128 + nc : $urandom_range(120, 135);
      repeat (reps) add_cell(r, k, 1'b0);
    end else begin
      n = $urandom_range(0, (nr > 4) ? 2 : nr);
      repeat (n) begin
        r = $urandom_range(0, nr - 1);
        for (k = 0; k < nc; k++) cut[r][k] = 1'b1;
      end
      n = $urandom_range(0, (nc > 4) ? 2 : nc);
      repeat (n) begin
        k = $urandom_range(0, nc - 1);
        for (r = 0; r < nr; r++) cut[r][k] = 1'b1;
      end
      // Small grids are often sent whole, kept cells included.
      fill = (nr * nc <= 64) && ($urandom_range(0, 1) != 0);
      for (r = 0; r < nr; r++)
        for (k = 0; k < nc; k++)
          if (cut[r][k]) add_cell(r, k, 1'b0);
          else if (fill) add_cell(r, k, 1'b1);
      if (flavour >= 60 && flavour < 70) begin
        // one extra removal somewhere inside the grid
        add_cell($urandom_range(0, nr - 1), $urandom_range(0, nc - 1), 1'b0);
      end else if (flavour >= 70 && flavour < 78) begin
        // drop a cell, usually leaving a row or column short
        if (batch.size() != 0) batch.delete($urandom_range(0, batch.size() - 1));
      end else if (flavour >= 78 && flavour < 87) begin
        // removed cell outside the configured grid
        if ($urandom_range(0, 1))
          add_cell($urandom_range(nr, 127), $urandom_range(0, 127), 1'b0);
        else
          add_cell($urandom_range(0, 127), $urandom_range(nc, 127), 1'b0);
      end else if (flavour >= 87 && flavour < 93) begin
        // repeat a cell already in the grid
        if (batch.size() != 0) begin
          t = batch[$urandom_range(0, batch.size() - 1)];
          batch.insert(batch.size(), t);
        end
      end else if (flavour >= 93) begin
        repeat ($urandom_range(1, 8))
          add_cell($urandom_range(0, 127), $urandom_range(0, 127), 1'($urandom_range(0, 1)));
      end
      // Kept cells anywhere in the coordinate space change nothing.
      repeat ($urandom_range(0, 2))
        add_cell($urandom_range(0, 127), $urandom_range(0, 127), 1'b1);
    end
    ship(1'b1);
  endfunction

  // Write one size register; only called with the block idle.
  task automatic write_reg(gcc_pkg::cfg_reg_e idx, logic [gcc_pkg::CNT_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == gcc_pkg::REG_GRID_ROWS) rows_set = val;
    else cols_set = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait for every cell to be taken and every verdict to come back, then
  // allow the block the requested extra cycles to fall idle.
  task automatic settle(int unsigned extra);
    while (cell_q.size() != 0 || s_axis_tvalid || verdicts_due.size() != 0)
      @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // Driver: change inputs on the falling edge. Hold a cell until its request
  // is taken, then offer the next one unless this cycle is an idle one.
  always @(negedge clk_i) begin : drive_cells
    cell_t nxt;
    logic  hold;
    hold = s_axis_tvalid && !cell_acc;
    if (!hold) begin
      if (rst_ni && cell_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = cell_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, nxt.kept, nxt.col, nxt.row};
        s_axis_tlast  <= nxt.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    // Stall the result side at random.
    m_axis_tready <= rst_ni && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Monitor: sample on the rising edge. Check each result request against the
  // oldest verdict owed, then fold any accepted cell into the tallies.
  always @(posedge clk_i) begin : watch_ports
    cell_t    got;
    verdict_t want;
    cell_acc <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        verdicts_checked++;
        if (verdicts_due.size() == 0) begin
          note_miss($sformatf("result %h arrived with no verdict owed", m_axis_tdata));
        end else begin
          want = verdicts_due.pop_front();
          if (m_axis_tdata[0] !== want.collapsible || m_axis_tdata[1] !== want.empty_grid)
            note_miss($sformatf("verdict %0d: collapsible %b/%b empty_grid %b/%b (exp/got)",
                                verdicts_checked, want.collapsible, m_axis_tdata[0],
                                want.empty_grid, m_axis_tdata[1]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        got.row  = s_axis_tdata[6:0];
        got.col  = s_axis_tdata[13:7];
        got.kept = s_axis_tdata[14];
        got.last = s_axis_tlast;
        absorb_cell(got);
      end
    end
  end

  // Watchdog: drop the run if no request of any kind is taken for too long.
  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no request taken for %0d cycles", STALL_LIMIT);
      $display("[grid_collapse_check] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned               era, phase, nr, nc, grids;
    logic [gcc_pkg::CNT_W-1:0] rv, cv;
    wipe_grid();
    send_idle_pct = 6;
    recv_idle_pct = 55;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Sizes are still zero after reset: the grid is empty whatever arrives.
    add_cell(127, 127, 1'b0);
    ship(1'b0);
    settle(8);
    write_reg(gcc_pkg::REG_GRID_ROWS, gcc_pkg::CNT_W'(2));
    write_reg(gcc_pkg::REG_GRID_COLS, gcc_pkg::CNT_W'(3));
    settings_written++;

    // Directed grids on a 2 x 3 grid.
    // whole row removed, one kept cell alongside
    add_cell(1, 0, 1'b0); add_cell(0, 0, 1'b1); add_cell(1, 1, 1'b0); add_cell(1, 2, 1'b0);
    ship(1'b0);
    // whole column removed
    add_cell(0, 2, 1'b0); add_cell(1, 2, 1'b0);
    ship(1'b0);
    // full row crossed by a full column
    add_cell(0, 0, 1'b0); add_cell(0, 1, 1'b0); add_cell(0, 2, 1'b0); add_cell(1, 1, 1'b0);
    ship(1'b0);
    // row left short
    add_cell(1, 0, 1'b0); add_cell(1, 1, 1'b0);
    ship(1'b0);
    // full column plus a removal past the last row
    add_cell(0, 2, 1'b0); add_cell(1, 2, 1'b0); add_cell(2, 2, 1'b0);
    ship(1'b0);
    // removal past the last column only
    add_cell(1, 127, 1'b0);
    ship(1'b0);
    // kept cells only, two of them at the coordinate extremes
    add_cell(0, 0, 1'b1); add_cell(127, 127, 1'b1); add_cell(42, 85, 1'b1);
    ship(1'b0);
    // repeated cell over-fills its row
    add_cell(0, 0, 1'b0); add_cell(0, 0, 1'b0); add_cell(0, 1, 1'b0); add_cell(0, 2, 1'b0);
    ship(1'b0);

    // Random grids in three idling patterns: slow results, then slow cells,
    // then full rate on both sides.
    phase = 0;
    for (era = 0; era < 3; era++) begin
      case (era)
        0: begin send_idle_pct = 6;  recv_idle_pct = 55; end
        1: begin send_idle_pct = 55; recv_idle_pct = 6;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      while (cells_queued < (era + 1) * CELL_BUDGET / 3) begin
        if (phase % 4 == 0) begin
          rv = fixed_rows[(phase / 4) % 9];
          cv = fixed_cols[(phase / 4) % 9];
        end else if ($urandom_range(0, 9) == 0) begin
          rv = gcc_pkg::CNT_W'($urandom_range(0, 64));
          cv = gcc_pkg::CNT_W'($urandom_range(0, 64));
        end else begin
          rv = gcc_pkg::CNT_W'($urandom_range(1, 8));
          cv = gcc_pkg::CNT_W'($urandom_range(1, 8));
        end
        settle(8);
        write_reg(gcc_pkg::REG_GRID_ROWS, rv);
        write_reg(gcc_pkg::REG_GRID_COLS, cv);
        settings_written++;
        nr    = span(rv, gcc_pkg::MAX_ROWS);
        nc    = span(cv, gcc_pkg::MAX_COLS);
        grids = (nr * nc > 256) ? 2 : $urandom_range(4, 10);
        repeat (grids)
          if (cells_queued < (era + 1) * CELL_BUDGET / 3) queue_grid(nr, nc);
        phase++;
      end
    end

    settle(gcc_pkg::WALK_LEN + 16);
    if (verdicts_due.size() != 0)
      note_miss($sformatf("%0d verdicts never arrived", verdicts_due.size()));
    $display("Sent %0d cells in %0d grids over %0d size settings; %0d verdicts compared.",
             cells_queued, grids_queued, settings_written, verdicts_checked);
    $display("Idling: results stalled, then cells gapped, then full rate; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("[grid_collapse_check] OK");
    end else begin
      $display("[grid_collapse_check] ERROR");
    end
    $finish;
  end

endmodule

// ===== grid_collapse_check.f =====
src/gcc_pkg.sv
src/gcc_ram.sv
src/gcc_update.sv
src/gcc_walk.sv
src/grid_collapse_check.sv
bench/tb_grid_collapse_check.sv
